// ===== src/mpq_pkg.sv =====
// Shared types and codes for the minimum priority queue.
package mpq_pkg;

  localparam int VALUE_W = 32;
  localparam int OCC_W   = 4;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  // broadcast to every cell
  typedef struct packed {
    op_t                        op;
    logic signed [VALUE_W-1:0]  value;
  } cell_cmd_t;

  // what a cell shows its neighbours
  typedef struct packed {
    logic                       occ;
    logic                       place;
    logic signed [VALUE_W-1:0]  value;
  } cell_link_t;

endpackage

// ===== src/mpq_req_if.sv =====
// Request and result channel interfaces of the minimum priority queue.
interface mpq_req_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [31:0] value;

  modport source (output valid, kind, value, input ready);
  modport sink   (input valid, kind, value, output ready);
endinterface

interface mpq_rsp_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] removed_value;
  logic [3:0]         occupancy;

  modport source (output valid, status, removed_value, occupancy, input ready);
  modport sink   (input valid, status, removed_value, occupancy, output ready);
endinterface

// ===== src/min_priority_queue.sv =====
// Top level of the minimum priority queue: sorted row of cells plus result register.
//
//   channel  modport  payload                              role
//   req      sink     kind, value                          insert / remove request
//   rsp      source   status, removed_value, occupancy     one result per request
//
// One request is taken per cycle while req.ready is high; its result is registered and shows in the cycle after.
// The cells keep entries sorted, smallest in cell 0, so insert and remove are one step.
// Reset (rst, synchronous) empties every cell and drops any pending result.
// req.ready falls only while a result is held and rsp.ready is low.
module min_priority_queue import mpq_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst,
  mpq_req_if.sink     req,
  mpq_rsp_if.source   rsp
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  cell_cmd_t               cmd;
  cell_link_t              links [DEPTH];
  cell_link_t              edge_left;
  cell_link_t              edge_right;
  logic                    accept;
  logic                    full;
  logic                    empty;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  logic [CNT_W+OCC_W-1:0]  count_ext;
  logic                    rsp_valid;
  status_t                 status;
  status_t                 status_next;
  logic signed [VALUE_W-1:0] removed_value;
  logic signed [VALUE_W-1:0] removed_next;
  logic [OCC_W-1:0]        occupancy;

  assign req.ready = !rsp_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign full      = links[DEPTH-1].occ;
  assign empty     = !links[0].occ;

  assign edge_left  = '{occ: 1'b0, place: 1'b0, value: '0};
  assign edge_right = '{occ: 1'b0, place: 1'b1, value: '0};

  always_comb begin
    cmd.value    = req.value;
    cmd.op       = OP_HOLD;
    status_next  = ST_OK;
    removed_next = '0;
    count_next   = count;
    if (req.kind == KIND_INSERT) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        cmd.op     = OP_INSERT;
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        cmd.op       = OP_REMOVE;
        removed_next = links[0].value;
        count_next   = count - CNT_W'(1);
      end
    end
    if (!accept) begin
      cmd.op = OP_HOLD;
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    mpq_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .cmd   (cmd),
      .left  ((i == 0) ? edge_left : links[(i == 0) ? 0 : i - 1]),
      .right ((i == DEPTH - 1) ? edge_right : links[(i == DEPTH - 1) ? i : i + 1]),
      .link  (links[i])
    );
  end

  assign count_ext = {{OCC_W{1'b0}}, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (accept) begin
        count     <= count_next;
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status        <= status_next;
      removed_value <= removed_next;
      occupancy     <= count_ext[OCC_W-1:0];
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.status        = status;
  assign rsp.removed_value = removed_value;
  assign rsp.occupancy     = occupancy;

endmodule

// ===== src/mpq_cell.sv =====
// One cell of the sorted queue: holds one entry, shifts with its neighbours.
module mpq_cell import mpq_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cell_cmd_t  cmd,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t link
);

  logic                      occ;
  logic signed [VALUE_W-1:0] value;
  logic                      occ_next;
  logic signed [VALUE_W-1:0] value_next;
  logic                      place;

  // new value belongs here or further left; empty cells count as +inf
  assign place = !occ || (cmd.value < value);

  always_comb begin
    occ_next   = occ;
    value_next = value;
    unique case (cmd.op)
      OP_INSERT: begin
        if (left.place) begin
          occ_next   = left.occ;
          value_next = left.value;
        end else if (place) begin
          occ_next   = 1'b1;
          value_next = cmd.value;
        end
      end
      OP_REMOVE: begin
        occ_next   = right.occ;
        value_next = right.value;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occ <= 1'b0;
    end else begin
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
  end

  assign link = '{occ: occ, place: place, value: value};

endmodule
